FILE: hdl/motd_pkg.sv
`default_nettype none
package motd_pkg;

  localparam int ACCEL_BITS_DEF = 16;
  localparam int RATE_BITS_DEF  = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int LEVEL_W     = 15;
  localparam int SHAKE_W     = 16;
  localparam int LEVEL_SQ_W  = 2 * LEVEL_W;

  localparam logic [CFG_INDEX_W-1:0] REG_INVERTED_LEVEL   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FREE_FALL_LEVEL  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAKE_RATE_LEVEL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FLAT_BAND        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_LEVEL       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAKE_STEP       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAKE_DECAY      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAKING_LEVEL    = 3'd7;

  localparam logic [LEVEL_W-1:0] INVERTED_LEVEL_RST   = 15'd2867;
  localparam logic [LEVEL_W-1:0] FREE_FALL_LEVEL_RST  = 15'd1229;
  localparam logic [LEVEL_W-1:0] SHAKE_RATE_LEVEL_RST = 15'd8000;
  localparam logic [LEVEL_W-1:0] FLAT_BAND_RST        = 15'd1229;
  localparam logic [LEVEL_W-1:0] TILT_LEVEL_RST       = 15'd2048;
  localparam logic [SHAKE_W-1:0] SHAKE_STEP_RST       = 16'd13107;
  localparam logic [SHAKE_W-1:0] SHAKE_DECAY_RST      = 16'd58982;
  localparam logic [SHAKE_W-1:0] SHAKING_LEVEL_RST    = 16'd19661;
  localparam logic [SHAKE_W-1:0] SHAKE_MAX            = 16'hFFFF;

  localparam logic [2:0] ORIENT_INVERTED  = 3'd0;
  localparam logic [2:0] ORIENT_FLAT      = 3'd1;
  localparam logic [2:0] ORIENT_LEFT      = 3'd2;
  localparam logic [2:0] ORIENT_RIGHT     = 3'd3;
  localparam logic [2:0] ORIENT_FORWARD   = 3'd4;
  localparam logic [2:0] ORIENT_BACK      = 3'd5;
  localparam logic [2:0] ORIENT_LEVEL     = 3'd6;

  typedef struct packed {
    logic       inverted;
    logic       free_fall;
    logic [2:0] orientation;
    logic       rate_over;
  } class_t;

endpackage
`default_nettype wire

FILE: hdl/motd_stream_if.sv
`default_nettype none
interface motd_sample_if #(
  parameter int ACCEL_BITS = motd_pkg::ACCEL_BITS_DEF,
  parameter int RATE_BITS  = motd_pkg::RATE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ACCEL_BITS-1:0] accel_x;
  logic signed [ACCEL_BITS-1:0] accel_y;
  logic signed [ACCEL_BITS-1:0] accel_z;
  logic signed [RATE_BITS-1:0]  rate_x;
  logic signed [RATE_BITS-1:0]  rate_y;
  logic signed [RATE_BITS-1:0]  rate_z;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

interface motd_result_if;
  logic        valid;
  logic        ready;
  logic        inverted;
  logic        free_fall;
  logic [2:0]  orientation;
  logic        shaking;
  logic [15:0] shake_amount;

  modport source (output valid, inverted, free_fall, orientation, shaking, shake_amount,
                  input ready);
  modport sink (input valid, inverted, free_fall, orientation, shaking, shake_amount,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/motd_classify.sv
`default_nettype none
module motd_classify #(
  parameter int ACCEL_BITS = motd_pkg::ACCEL_BITS_DEF,
  parameter int RATE_BITS  = motd_pkg::RATE_BITS_DEF
) (
  input  logic signed [ACCEL_BITS-1:0]         ax,
  input  logic signed [ACCEL_BITS-1:0]         ay,
  input  logic signed [ACCEL_BITS-1:0]         az,
  input  logic signed [RATE_BITS-1:0]          rx,
  input  logic signed [RATE_BITS-1:0]          ry,
  input  logic signed [RATE_BITS-1:0]          rz,
  input  logic [motd_pkg::LEVEL_W-1:0]         inverted_level,
  input  logic [motd_pkg::LEVEL_W-1:0]         flat_band,
  input  logic [motd_pkg::LEVEL_W-1:0]         tilt_level,
  input  logic [motd_pkg::LEVEL_SQ_W-1:0]      free_fall_sq,
  input  logic [motd_pkg::LEVEL_SQ_W-1:0]      shake_rate_sq,
  output motd_pkg::class_t                     cls
);
  import motd_pkg::*;

  localparam int CW  = ((ACCEL_BITS > LEVEL_W) ? ACCEL_BITS : LEVEL_W) + 2;
  localparam int ASW = 2 * ACCEL_BITS;
  localparam int RSW = 2 * RATE_BITS;
  localparam int ACW = (ASW > LEVEL_SQ_W) ? ASW : LEVEL_SQ_W;
  localparam int RCW = (RSW > LEVEL_SQ_W) ? RSW : LEVEL_SQ_W;

  logic signed [CW-1:0]  ax_e, ay_e, az_e;
  logic signed [CW-1:0]  inv_pos, band_pos, tilt_pos;
  logic signed [ASW-1:0] sq_ax, sq_ay, sq_az;
  logic signed [RSW-1:0] sq_rx, sq_ry, sq_rz;
  logic [ASW-1:0]        accel_sum;
  logic [RSW-1:0]        rate_sum;
  logic                  flat;

  assign ax_e     = CW'(ax);
  assign ay_e     = CW'(ay);
  assign az_e     = CW'(az);
  assign inv_pos  = $signed(CW'(inverted_level));
  assign band_pos = $signed(CW'(flat_band));
  assign tilt_pos = $signed(CW'(tilt_level));

  assign sq_ax = ASW'(ax) * ASW'(ax);
  assign sq_ay = ASW'(ay) * ASW'(ay);
  assign sq_az = ASW'(az) * ASW'(az);
  assign sq_rx = RSW'(rx) * RSW'(rx);
  assign sq_ry = RSW'(ry) * RSW'(ry);
  assign sq_rz = RSW'(rz) * RSW'(rz);

  // Each square is at most 2^(2n-2), so three of them still fit in 2n bits.
  assign accel_sum = $unsigned(sq_ax) + $unsigned(sq_ay) + $unsigned(sq_az);
  assign rate_sum  = $unsigned(sq_rx) + $unsigned(sq_ry) + $unsigned(sq_rz);

  assign flat = (ax_e < band_pos) && (ax_e > -band_pos) &&
                (ay_e < band_pos) && (ay_e > -band_pos);

  always_comb begin
    cls.inverted  = az_e < -inv_pos;
    cls.free_fall = ACW'(accel_sum) < ACW'(free_fall_sq);
    cls.rate_over = RCW'(rate_sum) > RCW'(shake_rate_sq);
    if (cls.inverted) begin
      cls.orientation = ORIENT_INVERTED;
    end else if (flat) begin
      cls.orientation = ORIENT_FLAT;
    end else if (ax_e > tilt_pos) begin
      cls.orientation = ORIENT_LEFT;
    end else if (ax_e < -tilt_pos) begin
      cls.orientation = ORIENT_RIGHT;
    end else if (ay_e > tilt_pos) begin
      cls.orientation = ORIENT_FORWARD;
    end else if (ay_e < -tilt_pos) begin
      cls.orientation = ORIENT_BACK;
    end else begin
      cls.orientation = ORIENT_LEVEL;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/motion_orientation_shake_detect_core.sv
// Orientation, free-fall and shake detector for a stream of IMU samples.
// The sample channel carries three signed accelerometer axes and three signed
// gyro axes; the result channel returns one result per sample: face down,
// free fall, orientation code, shaking flag and the updated shake level.
// Both channels use a valid/ready handshake; a transaction completes on a
// rising clock edge with valid and ready high.
// A sample is captured in an input register, classified by one pass of
// combinational logic and lands in the result register, which offers the
// result; a stall can hold the sample in the input register in between.
// One sample per cycle is sustained while the receiver takes results; the
// rate is set by the shake level feedback, which closes within that pass.
// When the receiver stalls, the result register holds, the input register
// takes one more sample only if it was empty, and sample ready then drops
// until the result moves on.
// Synchronous reset empties both registers, clears the shake level and loads
// the default thresholds. The user must have thresholds written through the
// configuration port only while no samples are in flight; no check is made.
`default_nettype none
module motion_orientation_shake_detect_core #(
  parameter int ACCEL_BITS = motd_pkg::ACCEL_BITS_DEF,
  parameter int RATE_BITS  = motd_pkg::RATE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [motd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [motd_pkg::CFG_DATA_W-1:0]   cfg_data,
  motd_sample_if.sink                       sample,
  motd_result_if.source                     result
);
  import motd_pkg::*;

  logic [LEVEL_W-1:0]    inverted_level, free_fall_level, shake_rate_level;
  logic [LEVEL_W-1:0]    flat_band, tilt_level;
  logic [SHAKE_W-1:0]    shake_step, shake_decay, shaking_level;
  logic [LEVEL_SQ_W-1:0] free_fall_sq, shake_rate_sq;

  logic                         s1_valid;
  logic signed [ACCEL_BITS-1:0] s1_ax, s1_ay, s1_az;
  logic signed [RATE_BITS-1:0]  s1_rx, s1_ry, s1_rz;

  logic               out_valid;
  logic [SHAKE_W-1:0] shake_level, shake_level_next;
  logic [SHAKE_W:0]   shake_sum;
  logic [2*SHAKE_W-1:0] shake_prod;
  logic               advance;
  class_t             cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverted_level   <= INVERTED_LEVEL_RST;
      free_fall_level  <= FREE_FALL_LEVEL_RST;
      shake_rate_level <= SHAKE_RATE_LEVEL_RST;
      flat_band        <= FLAT_BAND_RST;
      tilt_level       <= TILT_LEVEL_RST;
      shake_step       <= SHAKE_STEP_RST;
      shake_decay      <= SHAKE_DECAY_RST;
      shaking_level    <= SHAKING_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVERTED_LEVEL:   inverted_level   <= cfg_data[LEVEL_W-1:0];
        REG_FREE_FALL_LEVEL:  free_fall_level  <= cfg_data[LEVEL_W-1:0];
        REG_SHAKE_RATE_LEVEL: shake_rate_level <= cfg_data[LEVEL_W-1:0];
        REG_FLAT_BAND:        flat_band        <= cfg_data[LEVEL_W-1:0];
        REG_TILT_LEVEL:       tilt_level       <= cfg_data[LEVEL_W-1:0];
        REG_SHAKE_STEP:       shake_step       <= cfg_data[SHAKE_W-1:0];
        REG_SHAKE_DECAY:      shake_decay      <= cfg_data[SHAKE_W-1:0];
        REG_SHAKING_LEVEL:    shaking_level    <= cfg_data[SHAKE_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared thresholds are registered from their levels and follow a level
  // write in the next cycle.
  always_ff @(posedge clk) begin
    free_fall_sq  <= LEVEL_SQ_W'(free_fall_level) * LEVEL_SQ_W'(free_fall_level);
    shake_rate_sq <= LEVEL_SQ_W'(shake_rate_level) * LEVEL_SQ_W'(shake_rate_level);
  end

  assign advance      = !out_valid || result.ready;
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1_ax <= sample.accel_x;
      s1_ay <= sample.accel_y;
      s1_az <= sample.accel_z;
      s1_rx <= sample.rate_x;
      s1_ry <= sample.rate_y;
      s1_rz <= sample.rate_z;
    end
  end

  motd_classify #(
    .ACCEL_BITS (ACCEL_BITS),
    .RATE_BITS  (RATE_BITS)
  ) u_classify (
    .ax              (s1_ax),
    .ay              (s1_ay),
    .az              (s1_az),
    .rx              (s1_rx),
    .ry              (s1_ry),
    .rz              (s1_rz),
    .inverted_level  (inverted_level),
    .flat_band       (flat_band),
    .tilt_level      (tilt_level),
    .free_fall_sq    (free_fall_sq),
    .shake_rate_sq   (shake_rate_sq),
    .cls             (cls)
  );

  assign shake_sum  = {1'b0, shake_level} + {1'b0, shake_step};
  assign shake_prod = (2*SHAKE_W)'(shake_level) * (2*SHAKE_W)'(shake_decay);

  always_comb begin
    if (cls.rate_over) begin
      shake_level_next = shake_sum[SHAKE_W] ? SHAKE_MAX : shake_sum[SHAKE_W-1:0];
    end else begin
      shake_level_next = shake_prod[2*SHAKE_W-1:SHAKE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      shake_level <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        shake_level <= shake_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result.inverted     <= cls.inverted;
      result.free_fall    <= cls.free_fall;
      result.orientation  <= cls.orientation;
      result.shaking      <= shake_level_next > shaking_level;
      result.shake_amount <= shake_level_next;
    end
  end

  assign result.valid = out_valid;

endmodule
`default_nettype wire
